/* rtl/core/fat12_cluster_chain_walker_top_assert.svh */
// Assertion macros shared by the cluster chain walker files.
// FAT12CW_ASSERT checks a property while the block is out of reset.
// FAT12CW_ASSERT_RST checks a property on every clock edge, reset included.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FAT12CW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("fat12cw assertion failed");
`define FAT12CW_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("fat12cw reset assertion failed");
`else
`define FAT12CW_ASSERT(lbl, prop)
`define FAT12CW_ASSERT_RST(lbl, prop)
`endif
`endif

/* rtl/core/fat12cw_pkg.sv */
package fat12cw_pkg;

    // FAT store geometry. The store is split into an even and an odd bank.
    localparam int FAT_BYTES  = 8192;
    localparam int ADDR_W     = 13;
    localparam int BANK_DEPTH = FAT_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // Field widths.
    localparam int CLUS_W = 12;
    localparam int LBA_W  = 24;
    localparam int PROD_W = 20;
    localparam int DSL_W  = 16;
    localparam int SPC_W  = 8;
    localparam int CFG_W  = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // FAT12 entry constants.
    localparam logic [CLUS_W-1:0] ENTRY_MASK = 12'hFFF;
    localparam logic [CLUS_W-1:0] END_MARK   = 12'hFF8;
    localparam logic [CLUS_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

    // Opcodes on the input channel.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_LOW  = 2'd1;
    localparam logic [1:0] STAT_IDLE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DATA_START = 1'b0;
    localparam logic CFG_SPC        = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [DSL_W-1:0] DATA_START_RESET = 16'd33;
    localparam logic [SPC_W-1:0] SPC_RESET        = 8'd1;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_START   = 2'd1,
        KIND_ADVANCE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   fat_address;
        logic [7:0]          fat_byte;
        logic [CLUS_W-1:0]   start_cluster;
    } cmd_t;

endpackage

/* rtl/core/fat12cw_front.sv */
module fat12cw_front import fat12cw_pkg::*; (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: fat_address [12:0], fat_byte [20:13], start_cluster [32:21]
    input  logic [IN_DATA_W-1:0] s_tdata,
    // s_tuser: opcode [1:0]
    input  logic [1:0]           s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic known_op;

    // An item is taken whenever the queue has room; unused opcodes are dropped here.
    assign s_tready = !q_full;

    always_comb begin
        known_op = 1'b1;
        q_cmd.kind = KIND_LOAD;
        case (s_tuser)
            OP_LOAD:    q_cmd.kind = KIND_LOAD;
            OP_START:   q_cmd.kind = KIND_START;
            OP_ADVANCE: q_cmd.kind = KIND_ADVANCE;
            default:    known_op = 1'b0;
        endcase
        q_cmd.fat_address   = s_tdata[12:0];
        q_cmd.fat_byte      = s_tdata[20:13];
        q_cmd.start_cluster = s_tdata[32:21];
    end

    assign q_push = s_tvalid && !q_full && known_op;

endmodule

/* rtl/core/fat12cw_fifo.sv */
`include "fat12_cluster_chain_walker_top_assert.svh"

module fat12cw_fifo import fat12cw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_cmd = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue slots carry payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `FAT12CW_ASSERT(a_fifo_count_bound, count_reg <= QUEUE_CW'(QUEUE_DEPTH))
    `FAT12CW_ASSERT(a_fifo_no_underflow, pop |-> (count_reg != '0))
    `FAT12CW_ASSERT(a_fifo_no_overflow, (push && !pop) |-> !full)

endmodule

/* rtl/core/fat12cw_back.sv */
`include "fat12_cluster_chain_walker_top_assert.svh"

module fat12cw_back import fat12cw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  q_empty,
    input  cmd_t                  q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: cluster [11:0], sector_lba [35:12]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // m_tuser: status [1:0]
    output logic [1:0]            m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CLUS_W-1:0] next_clus_reg, next_clus_next;
    logic              chain_done_reg, chain_done_next;
    logic [DSL_W-1:0]  data_start_reg;
    logic [SPC_W-1:0]  spc_reg;

    // Visit context held across the memory read.
    logic [CLUS_W-1:0] visit_clus_reg;
    logic [LBA_W-1:0]  visit_lba_reg;
    logic              at_odd_reg;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    logic [CLUS_W-1:0] out_clus_reg, out_clus_next;
    logic [LBA_W-1:0]  out_lba_reg, out_lba_next;
    logic              out_last_reg, out_last_next;
    logic [1:0]        out_status_reg, out_status_next;

    // FAT store as even and odd byte banks.
    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];
    logic [7:0] even_rd_reg, odd_rd_reg;

    logic               out_free, out_load;
    logic               is_load, is_visit, idle_err, low_clus;
    logic [CLUS_W-1:0]  visit_clus;
    logic [ADDR_W-1:0]  at;
    logic [BANK_AW-1:0] even_idx, odd_idx;
    logic               rd_en, wr_en;
    logic [PROD_W-1:0]  prod;
    logic [LBA_W-1:0]   lba;
    logic [15:0]        word;
    logic [CLUS_W-1:0]  entry;
    logic               entry_last;

    assign out_free = !out_valid_reg || m_tready;

    // Decode the head command and work out its FAT address and sector.
    always_comb begin
        is_load    = (q_head.kind == KIND_LOAD);
        is_visit   = (q_head.kind == KIND_START) || (q_head.kind == KIND_ADVANCE);
        idle_err   = (q_head.kind == KIND_ADVANCE) && chain_done_reg;
        visit_clus = (q_head.kind == KIND_START) ? q_head.start_cluster : next_clus_reg;
        low_clus   = (visit_clus < FIRST_DATA_CLUSTER);
        at         = ADDR_W'(visit_clus) + ADDR_W'(visit_clus[CLUS_W-1:1]);
        odd_idx    = at[ADDR_W-1:1];
        even_idx   = at[ADDR_W-1:1] + BANK_AW'(at[0]);
        prod       = PROD_W'(visit_clus - FIRST_DATA_CLUSTER) * PROD_W'(spc_reg);
        lba        = LBA_W'(data_start_reg) + LBA_W'(prod);
    end

    // A load needs no result slot; a visit waits until the result register is free.
    assign q_pop = (state_reg == ST_IDLE) && !q_empty && (is_load || out_free);
    assign wr_en = q_pop && is_load &&
                   ({1'b0, q_head.fat_address} < (ADDR_W + 1)'(FAT_BYTES));
    assign rd_en = q_pop && is_visit && !idle_err && !low_clus;

    // Assemble the 12-bit entry from the two bytes read.
    always_comb begin
        word       = at_odd_reg ? {even_rd_reg, odd_rd_reg} : {odd_rd_reg, even_rd_reg};
        entry      = visit_clus_reg[0] ? word[15:4] : (word[11:0] & ENTRY_MASK);
        entry_last = (entry >= END_MARK);
    end

    // Sequencer and chain state.
    always_comb begin
        state_next      = state_reg;
        next_clus_next  = next_clus_reg;
        chain_done_next = chain_done_reg;
        out_load        = 1'b0;
        out_clus_next   = out_clus_reg;
        out_lba_next    = out_lba_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_pop && is_visit) begin
                    if (idle_err) begin
                        out_load        = 1'b1;
                        out_clus_next   = '0;
                        out_lba_next    = '0;
                        out_last_next   = 1'b1;
                        out_status_next = STAT_IDLE;
                    end else if (low_clus) begin
                        out_load        = 1'b1;
                        out_clus_next   = visit_clus;
                        out_lba_next    = '0;
                        out_last_next   = 1'b1;
                        out_status_next = STAT_LOW;
                        chain_done_next = 1'b1;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                out_load        = 1'b1;
                out_clus_next   = visit_clus_reg;
                out_lba_next    = visit_lba_reg;
                out_last_next   = entry_last;
                out_status_next = STAT_OK;
                next_clus_next  = entry;
                chain_done_next = entry_last;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            next_clus_reg  <= '0;
            chain_done_reg <= 1'b1;
            data_start_reg <= DATA_START_RESET;
            spc_reg        <= SPC_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_clus_reg  <= next_clus_next;
            chain_done_reg <= chain_done_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DATA_START: data_start_reg <= cfg_wdata;
                    CFG_SPC:        spc_reg        <= cfg_wdata[SPC_W-1:0];
                    default:        data_start_reg <= data_start_reg;
                endcase
            end
        end
    end

    // Payload registers of the visit context and the result.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            visit_clus_reg <= visit_clus;
            visit_lba_reg  <= lba;
            at_odd_reg     <= at[0];
        end
        out_clus_reg   <= out_clus_next;
        out_lba_reg    <= out_lba_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    // Even bank: one access per cycle, write or registered read.
    always_ff @(posedge aclk) begin
        if (wr_en && !q_head.fat_address[0]) begin
            even_mem[q_head.fat_address[ADDR_W-1:1]] <= q_head.fat_byte;
        end
        if (rd_en) begin
            even_rd_reg <= even_mem[even_idx];
        end
    end

    // Odd bank: one access per cycle, write or registered read.
    always_ff @(posedge aclk) begin
        if (wr_en && q_head.fat_address[0]) begin
            odd_mem[q_head.fat_address[ADDR_W-1:1]] <= q_head.fat_byte;
        end
        if (rd_en) begin
            odd_rd_reg <= odd_mem[odd_idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - LBA_W - CLUS_W){1'b0}}, out_lba_reg, out_clus_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    `FAT12CW_ASSERT(a_back_read_one_cycle, (state_reg == ST_READ) |=> (state_reg == ST_IDLE))
    `FAT12CW_ASSERT(a_back_no_overwrite, out_load |-> out_free)
    `FAT12CW_ASSERT(a_back_no_pop_in_read, (state_reg == ST_READ) |-> !q_pop)
    `FAT12CW_ASSERT_RST(a_back_reset_clear, !aresetn |=> (state_reg == ST_IDLE) && !out_valid_reg)

endmodule

/* rtl/core/fat12_cluster_chain_walker_top.sv */
// FAT12 cluster chain walker. Load items write single FAT bytes into an 8 KiB
// store, start items open a chain at a given cluster and advance items step to
// the stored next cluster; each start or advance yields one result with the
// cluster, its first sector and an end-of-chain flag, loads and unused opcodes
// yield none. The front end takes one transfer per cycle while its two-entry
// command queue has room, so it keeps accepting while a result waits on the
// output. The back end handles a load, or a visit that ends in an error status,
// in its idle state alone, and a normal visit in its idle and read states: the
// store is held as an even and an odd byte bank, both read into registers
// together, and the entry and chain state are settled in the read state, before
// the following command may start. The store needs no clearing pass after reset,
// but bytes must be loaded before a chain reads them.
// Configuration writes are taken at once and belong to idle periods only.
module fat12_cluster_chain_walker_top import fat12cw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: fat_address [12:0], fat_byte [20:13], start_cluster [32:21]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: opcode [1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: cluster [11:0], sector_lba [35:12]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // m_tuser: status [1:0]
    output logic [1:0]            m_tuser
);

    logic q_push, q_pop, q_full, q_empty;
    cmd_t push_cmd, head_cmd;

    // Front end: input handshake and opcode decode.
    fat12cw_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Command queue between front and back.
    fat12cw_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Back end: FAT store, chain state and result register.
    fat12cw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_empty   (q_empty),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

/* verif/fat12_walk_checker.sv */
`timescale 1ns / 100ps

// Watches both channels and the configuration port of the chain walker. It keeps
// its own image of the FAT and of the chain state, works out the result that each
// start or advance transfer should produce, and compares the result transfers in
// order against those expectations.
module fat12_walk_checker import fat12cw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // s_tdata: fat_address [12:0], fat_byte [20:13], start_cluster [32:21]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: opcode [1:0]
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: cluster [11:0], sector_lba [35:12]
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    // m_tuser: status [1:0]
    input  logic [1:0]            m_tuser,
    output int                    fail_count,
    output int                    results_due
);

    typedef struct packed {
        logic [CLUS_W-1:0] cluster;
        logic [LBA_W-1:0]  sector_lba;
        logic              last;
        logic [1:0]        status;
    } visit_t;

    logic [7:0]        fat_image [FAT_BYTES];
    logic [CLUS_W-1:0] next_clus;
    logic              chain_idle;
    logic [DSL_W-1:0]  data_start;
    logic [SPC_W-1:0]  spc;
    visit_t            visits_due [$];
    int                errors;

    // The entry of a cluster is the little-endian word at byte c*3/2; odd clusters
    // take its upper 12 bits, even clusters its lower 12 bits.
    function automatic logic [CLUS_W-1:0] fat_entry(input logic [CLUS_W-1:0] c);
        int          at;
        logic [15:0] word;
        at   = (int'(c) * 3) / 2;
        word = {fat_image[at + 1], fat_image[at]};
        return c[0] ? word[15:4] : word[11:0];
    endfunction

    // Visit one cluster: build the expected result and move the chain state on.
    function automatic visit_t visit_cluster(input logic [CLUS_W-1:0] c);
        visit_t v;
        v.cluster = c;
        if (c < FIRST_DATA_CLUSTER) begin
            v.sector_lba = '0;
            v.last       = 1'b1;
            v.status     = STAT_LOW;
            chain_idle   = 1'b1;
        end else begin
            v.sector_lba = LBA_W'(data_start)
                         + LBA_W'(c - FIRST_DATA_CLUSTER) * LBA_W'(spc);
            next_clus    = fat_entry(c);
            chain_idle   = (next_clus >= END_MARK);
            v.last       = chain_idle;
            v.status     = STAT_OK;
        end
        return v;
    endfunction

    task automatic report(input string field, input logic [LBA_W-1:0] want,
                          input logic [LBA_W-1:0] got);
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        visit_t want;
        if (!aresetn) begin
            next_clus  = '0;
            chain_idle = 1'b1;
            data_start = DATA_START_RESET;
            spc        = SPC_RESET;
            visits_due.delete();
            errors     = 0;
        end else begin
            // A result transfer is held against the oldest expectation.
            if (m_tvalid && m_tready) begin
                if (visits_due.size() == 0) begin
                    errors++;
                    $display("%0t: expected no result, got cluster %0h",
                             $time, m_tdata[CLUS_W-1:0]);
                end else begin
                    want = visits_due.pop_front();
                    if (m_tdata[CLUS_W-1:0] !== want.cluster)
                        report("cluster", LBA_W'(want.cluster),
                               LBA_W'(m_tdata[CLUS_W-1:0]));
                    if (m_tdata[CLUS_W +: LBA_W] !== want.sector_lba)
                        report("sector_lba", want.sector_lba, m_tdata[CLUS_W +: LBA_W]);
                    if (m_tlast !== want.last)
                        report("last", LBA_W'(want.last), LBA_W'(m_tlast));
                    if (m_tuser !== want.status)
                        report("status", LBA_W'(want.status), LBA_W'(m_tuser));
                end
            end

            // The user must make register writes only while the block is idle; it does not enforce this.
            if (cfg_we) begin
                if (cfg_index == CFG_DATA_START) data_start = cfg_wdata[DSL_W-1:0];
                else spc = cfg_wdata[SPC_W-1:0];
            end

            // Each load, start or advance transfer updates the FAT image or queues a result.
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_LOAD: begin
                        fat_image[s_tdata[ADDR_W-1:0]] = s_tdata[ADDR_W +: 8];
                    end
                    OP_START: begin
                        visits_due.push_back(visit_cluster(s_tdata[ADDR_W + 8 +: CLUS_W]));
                    end
                    OP_ADVANCE: begin
                        if (chain_idle) begin
                            want.cluster    = '0;
                            want.sector_lba = '0;
                            want.last       = 1'b1;
                            want.status     = STAT_IDLE;
                            visits_due.push_back(want);
                        end else begin
                            visits_due.push_back(visit_cluster(next_clus));
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        fail_count  <= errors;
        results_due <= visits_due.size();
    end

endmodule

/* verif/fat12_cluster_chain_walker_top_tb.sv */
`timescale 1ns / 100ps

module fat12_cluster_chain_walker_top_tb;
    import fat12cw_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         PHASE_ITEMS    = 175;
    localparam int         DRAIN_CYCLES   = 10;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;
    int                    fail_count;
    int                    results_due;

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    bit hold_req     = 1'b0;
    bit hold_taken   = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;

    // Stimulus-side view of the FAT and the chain, used only to keep every FAT
    // read on bytes that were loaded before.
    logic [7:0]        fat_shadow [FAT_BYTES];
    bit                fat_loaded [FAT_BYTES];
    logic [CLUS_W-1:0] walk_next = '0;
    bit                walk_done = 1'b1;
    logic [CLUS_W-1:0] entered [$];

    fat12_cluster_chain_walker_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    fat12_walk_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Ends the run when no transfer has happened for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int entry_at(input logic [CLUS_W-1:0] c);
        return (int'(c) * 3) / 2;
    endfunction

    function automatic logic [CLUS_W-1:0] entry_of(input logic [CLUS_W-1:0] c);
        int          at;
        logic [15:0] word;
        at   = entry_at(c);
        word = {fat_shadow[at + 1], fat_shadow[at]};
        return c[0] ? word[15:4] : word[11:0];
    endfunction

    // Visiting a cluster of two or more reads its entry, so both entry bytes must be loaded.
    function automatic bit entry_ready(input logic [CLUS_W-1:0] c);
        int at;
        at = entry_at(c);
        return (c < FIRST_DATA_CLUSTER) || (fat_loaded[at] && fat_loaded[at + 1]);
    endfunction

    function automatic bit can_advance();
        return walk_done || entry_ready(walk_next);
    endfunction

    function automatic void follow(input logic [CLUS_W-1:0] c);
        if (c < FIRST_DATA_CLUSTER) begin
            walk_done = 1'b1;
        end else begin
            walk_next = entry_of(c);
            walk_done = (walk_next >= END_MARK);
        end
    endfunction

    // Offers one input transfer, after a random gap, and waits until it is taken.
    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [7:0] value, input logic [CLUS_W-1:0] clus);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({clus, value, addr});
        do @(posedge aclk); while (!s_tready);
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic load_byte(input logic [ADDR_W-1:0] addr, input logic [7:0] value);
        send_item(OP_LOAD, addr, value, CLUS_W'($urandom_range(4095)));
        fat_shadow[addr] = value;
        fat_loaded[addr] = 1'b1;
    endtask

    task automatic start_chain(input logic [CLUS_W-1:0] c);
        send_item(OP_START, ADDR_W'($urandom_range(FAT_BYTES - 1)),
                  8'($urandom_range(255)), c);
        follow(c);
    endtask

    task automatic advance_chain();
        send_item(OP_ADVANCE, ADDR_W'($urandom_range(FAT_BYTES - 1)),
                  8'($urandom_range(255)), CLUS_W'($urandom_range(4095)));
        if (!walk_done) follow(walk_next);
    endtask

    // Writes one 12-bit entry with two byte loads, keeping the neighbor's nibble.
    task automatic set_entry(input logic [CLUS_W-1:0] c, input logic [CLUS_W-1:0] v);
        int         at;
        logic [3:0] keep_lo;
        logic [3:0] keep_hi;
        at      = entry_at(c);
        keep_lo = fat_loaded[at] ? fat_shadow[at][3:0] : 4'($urandom_range(15));
        keep_hi = fat_loaded[at + 1] ? fat_shadow[at + 1][7:4] : 4'($urandom_range(15));
        if (c[0]) begin
            load_byte(ADDR_W'(at), {v[3:0], keep_lo});
            load_byte(ADDR_W'(at + 1), v[11:4]);
        end else begin
            load_byte(ADDR_W'(at), v[7:0]);
            load_byte(ADDR_W'(at + 1), {keep_hi, v[11:8]});
        end
        entered.push_back(c);
    endtask

    // Mostly random clusters, some in the reserved range, some next to the last one
    // so that neighboring entries share a byte.
    function automatic logic [CLUS_W-1:0] pick_cluster(input logic [CLUS_W-1:0] near);
        int r;
        r = $urandom_range(99);
        if (r < 15) return CLUS_W'(12'hFF0 + $urandom_range(7));
        if (r < 35 && near > FIRST_DATA_CLUSTER && near < ENTRY_MASK)
            return $urandom_range(1) ? near + 12'd1 : near - 12'd1;
        return CLUS_W'($urandom_range(FIRST_DATA_CLUSTER, ENTRY_MASK));
    endfunction

    // Builds a short chain in the FAT, then walks it from its head.
    task automatic random_chain();
        logic [CLUS_W-1:0] path [$];
        int                len;
        len = $urandom_range(1, 6);
        path.push_back(pick_cluster('0));
        for (int i = 1; i < len; i++) path.push_back(pick_cluster(path[i - 1]));
        for (int i = 0; i < len; i++) begin
            if (i + 1 < len) set_entry(path[i], path[i + 1]);
            else if ($urandom_range(4) == 0) set_entry(path[i], CLUS_W'($urandom_range(1)));
            else set_entry(path[i], CLUS_W'($urandom_range(END_MARK, ENTRY_MASK)));
        end
        start_chain(path[0]);
        for (int i = 1; i < len + $urandom_range(1); i++) begin
            if (!can_advance()) break;
            advance_chain();
        end
    endtask

    task automatic random_step();
        int                pick;
        logic [CLUS_W-1:0] c;
        pick = $urandom_range(99);
        if (pick < 60) begin
            random_chain();
        end else if (pick < 75) begin
            c = ($urandom_range(9) == 0) ? CLUS_W'($urandom_range(1))
                                         : CLUS_W'($urandom_range(4095));
            if (!entry_ready(c)) c = entered[$urandom_range(entered.size() - 1)];
            start_chain(c);
        end else if (pick < 85) begin
            if (can_advance()) advance_chain();
            else start_chain(entered[$urandom_range(entered.size() - 1)]);
        end else if (pick < 95) begin
            load_byte(ADDR_W'($urandom_range(FAT_BYTES - 1)), 8'($urandom_range(255)));
        end else begin
            send_item(OP_UNUSED, ADDR_W'($urandom_range(FAT_BYTES - 1)),
                      8'($urandom_range(255)), CLUS_W'($urandom_range(4095)));
        end
    endtask

    // Lets every expected result arrive, then covers a load still in flight.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [DSL_W-1:0] dsl, input logic [SPC_W-1:0] spc_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DATA_START;
        cfg_wdata <= dsl;
        @(posedge aclk);
        cfg_index <= CFG_SPC;
        cfg_wdata <= CFG_W'(spc_val);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int target;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset configuration: advance with no chain, the
        // unused opcode, clusters below two, store extremes, a reserved entry that
        // is followed, end marks, and a chain that runs into cluster one.
        advance_chain();
        send_item(OP_UNUSED, '1, '1, '1);
        start_chain(12'd0);
        start_chain(12'd1);
        load_byte(13'h1FFF, 8'hFF);
        load_byte(13'h0000, 8'h00);
        set_entry(12'hFFF, 12'hFF0);
        set_entry(12'hFF0, 12'd2);
        set_entry(12'd2, ENTRY_MASK);
        start_chain(12'hFFF);
        advance_chain();
        advance_chain();
        advance_chain();
        set_entry(12'd3, 12'd1);
        start_chain(12'd3);
        advance_chain();
        advance_chain();
        wait_idle();

        // Random phases: two per idling mode, each with its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure(16'd0, 8'd1);
                1: configure(16'hFFFF, 8'd128);
                3: configure(16'hFFFF, 8'd1);
                4: configure(16'd0, 8'd128);
                default: configure(DSL_W'($urandom_range(16'hFFFF)),
                                   SPC_W'($urandom_range(1, 128)));
            endcase
            send_gap_pct = (ph < 2) ? 38 : (ph < 4) ? 45 : 0;
            recv_gap_pct = (ph < 2) ? 45 : (ph < 4) ? 38 : 0;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if (ph == 0 && !hold_req && items_sent > target - PHASE_ITEMS + 40)
                    hold_req = 1'b1;
                random_step();
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
